FILE: design/fpba_pkg.sv
// Shared types and codes for the fit-policy block allocator.
package fpba_pkg;

  localparam int unsigned CMD_W    = 1;
  localparam int unsigned BIDX_W   = 4;
  localparam int unsigned SVAL_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_REQ  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_LOADED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  localparam logic REG_FIT_MODE    = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BIDX_W-1:0] block_index;
    logic [SVAL_W-1:0] size_value;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BIDX_W-1:0]   chosen_block;
  } out_beat_t;

  typedef struct packed {
    logic [MODE_W-1:0] fit_mode;
    logic [CNT_W-1:0]  block_count;
  } cfg_t;

  // Search record control that walks down the cell row.
  typedef struct packed {
    logic vld;
    logic found;
  } cand_ctl_t;

endpackage

FILE: design/fpba_regs.sv
// APB register file for fit mode and block count.
module fpba_regs
  import fpba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [MODE_W-1:0] fit_mode_r;
  logic [CNT_W-1:0]  block_count_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r    <= MODE_FIRST;
      block_count_r <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_FIT_MODE:    fit_mode_r    <= pwdata[MODE_W-1:0];
        REG_BLOCK_COUNT: block_count_r <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FIT_MODE:    prdata = APB_DW'(fit_mode_r);
      REG_BLOCK_COUNT: prdata = APB_DW'(block_count_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.fit_mode    = fit_mode_r;
  assign cfg.block_count = block_count_r;

endmodule

FILE: design/fpba_cell.sv
// One table cell: holds a block size and refines the passing search record.
module fpba_cell
  import fpba_pkg::*;
#(
  parameter int unsigned SIZE_WIDTH = 16,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [BIDX_W-1:0]     wr_idx,
  input  logic [SIZE_WIDTH-1:0] wr_size,
  input  logic                  clr_en,
  input  logic [IDX_W-1:0]      clr_idx,
  input  cfg_t                  cfg,
  input  logic [SIZE_WIDTH-1:0] req_size,
  input  cand_ctl_t             ctl_in,
  input  logic [IDX_W-1:0]      pick_in,
  input  logic [SIZE_WIDTH-1:0] psize_in,
  output cand_ctl_t             ctl_out,
  output logic [IDX_W-1:0]      pick_out,
  output logic [SIZE_WIDTH-1:0] psize_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [SIZE_WIDTH-1:0] size_r;
  cand_ctl_t             ctl_r, ctl_nxt;
  logic [IDX_W-1:0]      pick_r, pick_nxt;
  logic [SIZE_WIDTH-1:0] psize_r, psize_nxt;
  logic                  in_range, fits, take;

  // Only entries below block_count take part; a zero request never fits.
  assign in_range = 32'(cfg.block_count) > CELL_IDX;
  assign fits     = ctl_in.vld && in_range && (req_size != '0) && (size_r >= req_size);

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!ctl_in.found) begin
        take = 1'b1;
      end else if (cfg.fit_mode == MODE_BEST) begin
        take = size_r < psize_in;
      end else if (cfg.fit_mode == MODE_WORST) begin
        take = size_r > psize_in;
      end
    end
    ctl_nxt.vld   = ctl_in.vld;
    ctl_nxt.found = ctl_in.found || fits;
    pick_nxt      = take ? MY_IDX : pick_in;
    psize_nxt     = take ? size_r : psize_in;
  end

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_idx) == CELL_IDX)) begin
      size_r <= wr_size;
    end else if (clr_en && (clr_idx == MY_IDX)) begin
      size_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pick_r  <= pick_nxt;
    psize_r <= psize_nxt;
  end

  assign ctl_out   = ctl_r;
  assign pick_out  = pick_r;
  assign psize_out = psize_r;

endmodule

FILE: design/fit_policy_block_allocator.sv
// Top level of the fit-policy block allocator: command port, APB registers, cell row.
//
// Usage:
//   A command beat (in_data) is taken at a rising edge with start high and busy low.
//   A load beat writes one table entry; its result (status load done) strobes
//   on out_strobe in the next cycle, and busy stays low, so loads go back to back.
//   A request beat raises busy and launches a search record into a row of
//   NUM_BLOCKS cells, one cell per cycle. Each cell holds one block size and
//   updates the best candidate under the fit mode (first, best or worst fit,
//   ties to the lowest index). The record leaves the last cell after passing
//   through every cell; the result strobes in the following cycle
//   while the chosen cell clears its entry and busy drops, so a new beat can be
//   taken in that same cycle. A request holds the port busy until its result;
//   the length of the cell row sets how long it is held.
//   Results show on out_strobe/out_data for one cycle; the receiver cannot stall.
//   Fit mode and block count are written over APB (addresses 0 and 4); the user does
//   so only while idle; the block does not enforce it. Reset (rst_n low, synchronous)
//   clears busy, the strobe, the registers and the search records; table entries hold nothing defined until loaded.
module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned SIZE_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_beat_t          in_data,
  output logic              out_strobe,
  output out_beat_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  cfg_t                  cfg;
  logic                  accept, load_go, req_go;
  logic [31:0]           size_ext;
  logic [SIZE_WIDTH-1:0] in_size;
  logic                  busy_r, busy_nxt;
  logic                  launch_r;
  logic [SIZE_WIDTH-1:0] req_size_r;
  logic                  out_vld_r, out_vld_nxt;
  out_beat_t             out_r, out_nxt;
  logic                  done, clr_en;
  logic [31:0]           pick_ext;

  cand_ctl_t             ctl   [NUM_BLOCKS+1];
  logic [IDX_W-1:0]      pick  [NUM_BLOCKS+1];
  logic [SIZE_WIDTH-1:0] psize [NUM_BLOCKS+1];

  fpba_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Take the low SIZE_WIDTH bits of the size, zero-extended where the field is narrower.
  assign size_ext = 32'(in_data.size_value);
  assign in_size  = size_ext[SIZE_WIDTH-1:0];

  assign accept  = start && !busy_r;
  assign load_go = accept && (in_data.cmd == CMD_LOAD);
  assign req_go  = accept && (in_data.cmd == CMD_REQ);

  // Hold the requested size for the whole walk; launch the record in the cycle after acceptance.
  always_ff @(posedge clk) begin
    if (req_go) begin
      req_size_r <= in_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r <= 1'b0;
    end else begin
      launch_r <= req_go;
    end
  end

  assign ctl[0].vld   = launch_r;
  assign ctl[0].found = 1'b0;
  assign pick[0]      = '0;
  assign psize[0]     = '0;

  // Record leaving the last cell finishes the search; clear the winner now.
  assign done   = ctl[NUM_BLOCKS].vld;
  assign clr_en = done && ctl[NUM_BLOCKS].found;

  for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
    fpba_cell #(
      .SIZE_WIDTH (SIZE_WIDTH),
      .IDX_W      (IDX_W),
      .CELL_IDX   (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (load_go),
      .wr_idx    (in_data.block_index),
      .wr_size   (in_size),
      .clr_en    (clr_en),
      .clr_idx   (pick[NUM_BLOCKS]),
      .cfg       (cfg),
      .req_size  (req_size_r),
      .ctl_in    (ctl[k]),
      .pick_in   (pick[k]),
      .psize_in  (psize[k]),
      .ctl_out   (ctl[k+1]),
      .pick_out  (pick[k+1]),
      .psize_out (psize[k+1])
    );
  end

  assign pick_ext = 32'(pick[NUM_BLOCKS]);

  always_comb begin
    busy_nxt    = busy_r;
    out_vld_nxt = 1'b0;
    out_nxt     = out_r;
    if (req_go) begin
      busy_nxt = 1'b1;
    end
    if (load_go) begin
      out_vld_nxt          = 1'b1;
      out_nxt.status       = ST_LOADED;
      out_nxt.chosen_block = '0;
    end
    if (done) begin
      busy_nxt    = 1'b0;
      out_vld_nxt = 1'b1;
      if (ctl[NUM_BLOCKS].found) begin
        out_nxt.status       = ST_ALLOC;
        out_nxt.chosen_block = pick_ext[BIDX_W-1:0];
      end else begin
        out_nxt.status       = ST_NONE;
        out_nxt.chosen_block = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

`ifndef SYNTHESIS
  // An accepted request must hold the port busy while the record walks.
  a_req_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.cmd == CMD_REQ)) |=> busy)
    else $error("request accepted without raising busy");

  // A search result leaves exactly when busy drops.
  a_result_release : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_data.status != ST_LOADED)) |-> $fell(busy))
    else $error("search result without busy release");

  // A failed search reports block zero.
  a_none_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_data.status == ST_NONE)) |-> (out_data.chosen_block == '0))
    else $error("not-allocated result with nonzero block");
`endif

endmodule

FILE: tb/sv/fit_policy_block_allocator_test.sv
// Self-checking testbench for the fit-policy block allocator: directed and random beats.
module fit_policy_block_allocator_test;
  import fpba_pkg::*;

  localparam int unsigned NUM_BLOCKS = 16;
  localparam int unsigned SIZE_WIDTH = 16;
  // A request holds the port while its record walks the cell row; allow some slack on top.
  localparam int unsigned DRAIN_CYCLES = NUM_BLOCKS + 4;
  // Slowest legal stretch without any handshake is the longest driver gap plus a full search,
  // or a register update pause; this is many times that.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_BEATS = 85;
  // The package names three placement codes; the fourth encoding falls back to first fit.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_beat_t          in_data = '0;
  logic              out_strobe;
  out_beat_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  fit_policy_block_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .SIZE_WIDTH(SIZE_WIDTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mirror of the allocator: free-size table plus the two registers.
  logic [SVAL_W-1:0] free_size [NUM_BLOCKS];
  logic [MODE_W-1:0] mode_now = MODE_FIRST;
  logic [CNT_W-1:0]  count_now = '0;

  in_beat_t  cmd_q [$];   // beats waiting for the driver
  out_beat_t due_q [$];   // outcomes owed by the block, oldest first

  int unsigned queued_beats = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  int          errors = 0;
  logic        beat_taken = 1'b0;
  logic        calm = 1'b0;

  // Compute the outcome of one accepted beat and advance the mirrored table.
  // Ties go to the lowest index in every mode, so only a strict improvement
  // moves the pick. A zero-size request never matches anything.
  function automatic out_beat_t alloc_outcome(in_beat_t b);
    out_beat_t   r;
    int unsigned span;
    bit          hit;
    int unsigned pick;
    r = '0;
    if (b.cmd == CMD_LOAD) begin
      free_size[b.block_index] = b.size_value;
      r.status = ST_LOADED;
      return r;
    end
    // Saturate an oversized count to the table depth.
    span = (count_now > NUM_BLOCKS) ? NUM_BLOCKS : count_now;
    hit = 1'b0;
    pick = 0;
    if (b.size_value != '0) begin
      for (int unsigned j = 0; j < span; j++) begin
        if (free_size[j] < b.size_value) continue;
        if (!hit) begin
          hit = 1'b1;
          pick = j;
          // First fit, and the spare encoding, stop at the first match.
          if (mode_now != MODE_BEST && mode_now != MODE_WORST) break;
        end else if (mode_now == MODE_BEST && free_size[j] < free_size[pick]) begin
          pick = j;
        end else if (mode_now == MODE_WORST && free_size[j] > free_size[pick]) begin
          pick = j;
        end
      end
    end
    if (hit) begin
      free_size[pick] = '0;
      r.status = ST_ALLOC;
      r.chosen_block = pick[BIDX_W-1:0];
    end else begin
      r.status = ST_NONE;
    end
    return r;
  endfunction

  // Size mix: tiny, byte-range, single powers of two, all-ones, small multiples of 256 and full random,
  // so that loads and requests collide often and every bit toggles.
  function automatic logic [SVAL_W-1:0] pick_size();
    case ($urandom_range(0, 5))
      0: return SVAL_W'($urandom_range(1, 15));
      1: return SVAL_W'($urandom_range(0, 255));
      2: return SVAL_W'(1) << $urandom_range(0, SVAL_W - 1);
      3: return '1;
      4: return SVAL_W'($urandom_range(0, 7)) << 8;
      default: return SVAL_W'($urandom);
    endcase
  endfunction

  task automatic queue_beat(logic [CMD_W-1:0] cmd, logic [BIDX_W-1:0] idx,
                            logic [SVAL_W-1:0] size);
    in_beat_t b;
    b.cmd = cmd;
    b.block_index = idx;
    b.size_value = size;
    cmd_q.push_back(b);
    queued_beats++;
  endtask

  // One APB write: setup cycle, access cycle, then release the bus.
  // The mirror follows once the access edge has passed.
  task automatic reg_write(logic reg_sel, logic [APB_DW-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_FIT_MODE) mode_now = value[MODE_W-1:0];
    else count_now = value[CNT_W-1:0];
  endtask

  // Hold until every queued beat has produced its result, then let the
  // chosen cell finish clearing before the registers move.
  task automatic drain();
    while (results_seen < queued_beats) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_policy(logic [MODE_W-1:0] mode, logic [CNT_W-1:0] count);
    drain();
    reg_write(REG_FIT_MODE, APB_DW'(mode));
    reg_write(REG_BLOCK_COUNT, APB_DW'(count));
    calm = ($urandom_range(0, 3) == 0);
    @(posedge clk);
  endtask

  // Driver: present the next beat at the falling edge once the previous one
  // was taken, after the idle gap drawn for it. Hold start while busy.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        in_data <= cmd_q.pop_front();
        start <= 1'b1;
        gap_left <= calm ? 0 : $urandom_range(0, 4);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check strobed results against the oldest owed outcome, predict
  // each accepted beat, and run the no-progress watchdog.
  always @(posedge clk) begin : monitor
    out_beat_t want;
    if (!rst_n) begin
      beat_taken <= 1'b0;
    end else begin
      if (out_strobe) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d block=%0d", $time,
                   out_data.status, out_data.chosen_block);
          errors++;
        end else begin
          want = due_q.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_data.status);
            errors++;
          end
          if (out_data.chosen_block !== want.chosen_block) begin
            $display("%0t: chosen_block expected %0d actual %0d", $time,
                     want.chosen_block, out_data.chosen_block);
            errors++;
          end
        end
        results_seen <= results_seen + 1;
      end
      // Compare before predicting: a result and the next beat share an edge.
      if (start && !busy) due_q.push_back(alloc_outcome(in_data));
      beat_taken <= start && !busy;
      if (out_strobe || (start && !busy) || (psel && penable && pwrite && pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Table contents for the opening loads: ties at the top (0xFFFF twice),
  // ties in the middle (0x0010 and 0x0100 twice each) and one zero entry.
  logic [SVAL_W-1:0] seed_sizes [NUM_BLOCKS] = '{
    16'h0010, 16'h0100, 16'h0010, 16'hFFFF, 16'h0008, 16'h0100, 16'h7FFF, 16'h0000,
    16'h8000, 16'h0200, 16'h00FF, 16'h1234, 16'h0FFF, 16'h0400, 16'h0002, 16'hFFFF
  };

  initial begin
    int unsigned n_load;
    int unsigned n_req;
    int unsigned issued;
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  count;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // First fit over the full table. Load every entry before any search so
    // nothing undefined is ever read.
    set_policy(MODE_FIRST, CNT_W'(NUM_BLOCKS));
    for (int i = 0; i < NUM_BLOCKS; i++) queue_beat(CMD_LOAD, BIDX_W'(i), seed_sizes[i]);
    queue_beat(CMD_REQ, '1, '0);          // zero-size request: not allocated
    queue_beat(CMD_REQ, '0, 16'h0001);    // lowest index fits
    queue_beat(CMD_REQ, '0, '1);          // largest size, first of two equal
    queue_beat(CMD_REQ, '1, '1);          // the other one
    queue_beat(CMD_REQ, '0, '1);          // nothing fits any more

    // Best fit with an oversized count: it saturates to the table depth.
    set_policy(MODE_BEST, '1);
    queue_beat(CMD_REQ, '0, 16'h0009);
    queue_beat(CMD_REQ, '0, 16'h0100);    // tie between two equal blocks

    set_policy(MODE_WORST, CNT_W'(NUM_BLOCKS));
    queue_beat(CMD_REQ, '0, 16'h0001);

    // Spare mode encoding with an empty search range.
    set_policy(MODE_SPARE, '0);
    queue_beat(CMD_REQ, '0, 16'h0001);

    // Random phases: bursts of loads refill the table, then a few requests
    // search it. Some bursts carry no loads at all and just drain the table.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode = MODE_W'($urandom_range(0, 3));
      case ($urandom_range(0, 4))
        0: count = CNT_W'(NUM_BLOCKS);
        1: count = CNT_W'($urandom_range(NUM_BLOCKS + 1, 31));
        2: count = '0;
        default: count = CNT_W'($urandom_range(1, NUM_BLOCKS));
      endcase
      set_policy(mode, count);
      issued = 0;
      while (issued < PHASE_BEATS) begin
        n_load = $urandom_range(0, 6);
        n_req = $urandom_range(1, 5);
        repeat (n_load) queue_beat(CMD_LOAD, BIDX_W'($urandom_range(0, NUM_BLOCKS - 1)),
                                   pick_size());
        repeat (n_req) queue_beat(CMD_REQ, BIDX_W'($urandom), pick_size());
        issued += n_load + n_req;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (due_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, due_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
